// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed");

// Condition that must never hold outside reset
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("forbidden condition");

`endif

// ----- hdl/fpe2_pkg.sv -----
`timescale 1ns / 1ps
package fpe2_pkg;
	localparam int STEP_COUNT      = 16;
	localparam int STEPS_PER_STAGE = 2;
	localparam int STEP_STAGES     = STEP_COUNT / STEPS_PER_STAGE;
	localparam int DIV_BITS        = 34;
	localparam int BITS_PER_STAGE  = 2;
	localparam int DIV_STAGES      = DIV_BITS / BITS_PER_STAGE;
	localparam logic [63:0] ONE_Q16 = 64'h10000;

	// log2(1 + 2^-(k+1)) in Q16
	function automatic logic [15:0] log2_step(input logic [3:0] k);
		logic [15:0] t;
		case (k)
			4'd0:  t = 16'h95c0;
			4'd1:  t = 16'h526a;
			4'd2:  t = 16'h2b80;
			4'd3:  t = 16'h1664;
			4'd4:  t = 16'h0b5d;
			4'd5:  t = 16'h05ba;
			4'd6:  t = 16'h02e0;
			4'd7:  t = 16'h0171;
			4'd8:  t = 16'h00b8;
			4'd9:  t = 16'h005c;
			4'd10: t = 16'h002e;
			4'd11: t = 16'h0017;
			4'd12: t = 16'h000c;
			4'd13: t = 16'h0006;
			4'd14: t = 16'h0003;
			4'd15: t = 16'h0001;
			default: t = 16'h0000;
		endcase
		return t;
	endfunction
endpackage

// ----- hdl/fpe2_div.sv -----
`timescale 1ns / 1ps
module fpe2_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] acc,
	input  logic        pos,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] power_q16
);
	import fpe2_pkg::*;

	logic              v_sd   [DIV_STAGES];
	logic [34:0]       r_sd   [DIV_STAGES];
	logic [DIV_BITS-1:0] q_sd [DIV_STAGES];
	logic [63:0]       d_sd   [DIV_STAGES];
	logic              pos_sd [DIV_STAGES];
	logic              take_sd[DIV_STAGES];
	logic              take_o;

	// free the output register when empty or when its transaction leaves
	assign take_o = !out_valid || !out_stall;
	assign in_stall = !take_sd[0];

	genvar s;
	generate
		for (s = 0; s < DIV_STAGES; s++) begin : g_div
			logic              src_v;
			logic [34:0]       src_r;
			logic [DIV_BITS-1:0] src_q;
			logic [63:0]       src_d;
			logic              src_pos;
			logic [34:0]       nxt_r;
			logic [DIV_BITS-1:0] nxt_q;

			if (s == 0) begin : g_first
				assign src_v   = in_valid;
				assign src_r   = '0;
				assign src_q   = '0;
				assign src_d   = acc;
				assign src_pos = pos;
			end else begin : g_next
				assign src_v   = v_sd[s-1];
				assign src_r   = r_sd[s-1];
				assign src_q   = q_sd[s-1];
				assign src_d   = d_sd[s-1];
				assign src_pos = pos_sd[s-1];
			end

			if (s == DIV_STAGES - 1) begin : g_last
				assign take_sd[s] = !v_sd[s] || take_o;
			end else begin : g_mid
				assign take_sd[s] = !v_sd[s] || take_sd[s+1];
			end

			// two restoring steps on the dividend 2^32
			always_comb begin
				nxt_r = src_r;
				nxt_q = src_q;
				for (int b = 0; b < BITS_PER_STAGE; b++) begin
					nxt_r = {nxt_r[33:0],
						(DIV_BITS - 1 - (s * BITS_PER_STAGE + b)) == 32};
					if ({29'b0, nxt_r} >= src_d) begin
						nxt_r = nxt_r - src_d[34:0];
						nxt_q[DIV_BITS - 1 - (s * BITS_PER_STAGE + b)] = 1'b1;
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_sd[s] <= 1'b0;
				end else if (take_sd[s]) begin
					v_sd[s] <= src_v;
				end
			end

			always_ff @(posedge clk) begin
				if (take_sd[s] && src_v) begin
					r_sd[s]   <= nxt_r;
					q_sd[s]   <= nxt_q;
					d_sd[s]   <= src_d;
					pos_sd[s] <= src_pos;
				end
			end
		end
	endgenerate

	// select the result and hold it until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take_o) begin
			out_valid <= v_sd[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (take_o && v_sd[DIV_STAGES-1]) begin
			if (pos_sd[DIV_STAGES-1])
				power_q16 <= d_sd[DIV_STAGES-1][31:0];
			else if (d_sd[DIV_STAGES-1] == '0)
				power_q16 <= '0;
			else
				power_q16 <= q_sd[DIV_STAGES-1][31:0];
		end
	end
endmodule

// ----- hdl/fixed_point_exp2_q16.sv -----
`timescale 1ns / 1ps
// Pipeline: 1 entry stage, 8 shift-add stages of two steps each, 17 divider
// stages and an output register between accepted transaction and result.
// Throughput: one transaction per cycle when not stalled; each stage refills
// its slot independently, so bubbles close up while the output is stalled.
// Reset: arst_n clears all valid bits asynchronously; payload is not reset.
`include "assert_macros.svh"
module fixed_point_exp2_q16 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] exponent_q16,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        power_q16
);
	import fpe2_pkg::*;

	logic        v_s1, pos_s1, take_s1;
	logic [15:0] frac_s1;
	logic [63:0] acc_s1;
	logic [31:0] mag;
	logic        is_pos;

	logic        v_st   [STEP_STAGES];
	logic        pos_st [STEP_STAGES];
	logic [15:0] frac_st[STEP_STAGES];
	logic [63:0] acc_st [STEP_STAGES];
	logic        take_st[STEP_STAGES];
	logic        div_stall;

	// take the magnitude and apply the integer shift
	assign mag    = exponent_q16[31] ? 32'(32'd0 - $unsigned(exponent_q16))
		: $unsigned(exponent_q16);
	assign is_pos = !exponent_q16[31] && (exponent_q16 != '0);
	assign take_s1  = !v_s1 || take_st[0];
	assign in_stall = !take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && in_valid) begin
			pos_s1  <= is_pos;
			frac_s1 <= mag[15:0];
			acc_s1  <= ONE_Q16 << mag[21:16];
		end
	end

	genvar s;
	generate
		for (s = 0; s < STEP_STAGES; s++) begin : g_step
			logic        src_v, src_pos;
			logic [15:0] src_frac, nxt_frac, thr;
			logic [63:0] src_acc, nxt_acc;

			if (s == 0) begin : g_first
				assign src_v    = v_s1;
				assign src_pos  = pos_s1;
				assign src_frac = frac_s1;
				assign src_acc  = acc_s1;
			end else begin : g_next
				assign src_v    = v_st[s-1];
				assign src_pos  = pos_st[s-1];
				assign src_frac = frac_st[s-1];
				assign src_acc  = acc_st[s-1];
			end

			if (s == STEP_STAGES - 1) begin : g_last
				assign take_st[s] = !v_st[s] || !div_stall;
			end else begin : g_mid
				assign take_st[s] = !v_st[s] || take_st[s+1];
			end

			// two shift-add steps against the log2 thresholds
			always_comb begin
				nxt_frac = src_frac;
				nxt_acc  = src_acc;
				thr      = '0;
				for (int j = 0; j < STEPS_PER_STAGE; j++) begin
					thr = log2_step(4'(s * STEPS_PER_STAGE + j));
					if (thr <= nxt_frac) begin
						nxt_frac = nxt_frac - thr;
						nxt_acc  = nxt_acc + (nxt_acc >> (s * STEPS_PER_STAGE + j + 1));
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_st[s] <= 1'b0;
				end else if (take_st[s]) begin
					v_st[s] <= src_v;
				end
			end

			always_ff @(posedge clk) begin
				if (take_st[s] && src_v) begin
					pos_st[s]  <= src_pos;
					frac_st[s] <= nxt_frac;
					acc_st[s]  <= nxt_acc;
				end
			end
		end
	endgenerate

	fpe2_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_st[STEP_STAGES-1]),
		.in_stall  (div_stall),
		.acc       (acc_st[STEP_STAGES-1]),
		.pos       (pos_st[STEP_STAGES-1]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.power_q16 (power_q16)
	);

	`ASSERT_CLK(a_stall_needs_full, in_stall |-> v_s1)
	`ASSERT_CLK(a_hold_s1, v_s1 && !take_s1 |=> v_s1 && $stable(acc_s1))
	`ASSERT_NEVER(a_step_hold_lost, v_st[0] && !take_st[0] && !v_s1 && in_stall)
endmodule
